@@ hdl/htd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Huffman tree decoder: sizes, field codes and shared types.
// Depends on nothing; the core, the decode tracker and the test import it.
package htd_pkg;

  localparam int unsigned NodeCapacity = 512;
  localparam int unsigned StackDepth   = 256;

  localparam int unsigned NodeW     = $clog2(NodeCapacity);
  localparam int unsigned LinkW     = $clog2(NodeCapacity + 1);
  localparam int unsigned StackW    = $clog2(StackDepth);
  localparam int unsigned StackCntW = $clog2(StackDepth + 1);

  // Preorder byte that stands for an empty child ('~').
  localparam logic [7:0] EmptyMark = 8'd126;

  typedef enum logic [1:0] {
    FUNC_CLEAR     = 2'd0,
    FUNC_TREE_BYTE = 2'd1,
    FUNC_CODE_BIT  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NOT_READY   = 3'd1,
    STAT_TREE_DONE   = 3'd2,
    STAT_OVERFLOW    = 3'd3,
    STAT_EMPTY_CHILD = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tree_char;
    logic       code_bit;
  } item_t;

  typedef struct packed {
    logic       symbol_valid;
    logic [7:0] symbol;
    logic       tree_ready;
    status_e    status;
  } result_t;

endpackage

@@ hdl/htd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the Huffman tree decoder.
// Depends on htd_pkg for nothing but keeps the same field widths by hand.
interface htd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] tree_char;
  logic       code_bit;

  modport source (output valid, output func, output tree_char, output code_bit, input ready);
  modport sink   (input valid, input func, input tree_char, input code_bit, output ready);
endinterface

interface htd_out_if;
  logic       valid;
  logic       ready;
  logic       symbol_valid;
  logic [7:0] symbol;
  logic       tree_ready;
  logic [2:0] status;

  modport source (output valid, output symbol_valid, output symbol, output tree_ready,
                  output status, input ready);
  modport sink   (input valid, input symbol_valid, input symbol, input tree_ready,
                  input status, output ready);
endinterface

@@ hdl/huffman_tree_decoder_core.sv @@
`timescale 1ns / 1ps
// Huffman tree decoder core: preorder tree load into a node table, then a
// bit-serial tree walk. Depends on htd_pkg and the channels in htd_if.sv.
//
// Usage. Items arrive on in_i (valid/ready). An item with func clear empties
// the tree, tree-byte items carry the preorder tree, and code-bit items carry
// the encoded stream one bit each. Every item produces exactly one result
// item on out_o: the decoded symbol when a leaf was reached, the load state
// and a status code.
// Timing. The node table and the pending stack are read at the edge that
// accepts an item, the item is processed in the following cycle, and its
// result enters a two-entry output queue at the next edge. No new item is
// taken while one is in process: the node read for one code bit depends on
// the node that the previous bit reached, and memory reads are registered.
// Reset clears the load and walk state (no tree, cursor at the root); the
// memories are not cleared, since nothing reads an entry before it is
// written. When the receiver stalls, up to two results wait in the output
// queue while input items are still taken; the input stalls when the queue
// is full and while an item is being processed.
module huffman_tree_decoder_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  htd_in_if.sink   in_i,
  htd_out_if.source out_o
);
  import htd_pkg::*;

  // Node table, split into field lanes. The zero child of a node is always
  // the node created right after it (preorder), so only a flag is stored for
  // it; the one child is stored as index plus one, zero meaning empty.
  logic [7:0]       lbl_mem [NodeCapacity];
  logic             hz_mem  [NodeCapacity];
  logic [LinkW-1:0] one_mem [NodeCapacity];

  // Pending stack. Only one-side slots live in memory: a zero-side slot can
  // only ever sit on top and always belongs to the newest node, so a flag
  // stands for it.
  logic [NodeW-1:0] stk_mem [StackDepth];

  // Control state.
  logic                 busy_q;
  item_t                item_q;
  logic [LinkW-1:0]     nodes_used_q, nodes_used_d;
  logic [StackCntW-1:0] s1_cnt_q, s1_cnt_d;
  logic                 zflag_q, zflag_d;
  logic                 root_seen_q, root_seen_d;
  logic                 load_done_q, load_done_d;
  logic                 at_root_q, at_root_d;

  // Cached records of the root and of the current cursor node.
  logic [7:0]       root_label_q, root_label_d;
  logic             root_hz_q, root_hz_d;
  logic [LinkW-1:0] root_one_q, root_one_d;
  logic [NodeW-1:0] cur_idx_q, cur_idx_d;
  logic             cur_hz_q, cur_hz_d;
  logic [LinkW-1:0] cur_one_q, cur_one_d;

  // Registered memory read data.
  logic [7:0]       rd_lbl_q;
  logic             rd_hz_q;
  logic [LinkW-1:0] rd_one_q;
  logic [NodeW-1:0] stk_rd_q;

  // Output queue.
  result_t    oq_q [2];
  logic       oq_wr_q, oq_rd_q;
  logic [1:0] oq_cnt_q;

  logic in_fire, out_fire;

  assign in_i.ready = !busy_q && (oq_cnt_q != 2'd2);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;

  // ------------------------------------------------------------------
  // Link selection from the cursor record. The cached records only change
  // when an item completes, so the same value serves the read address at
  // acceptance and the decision in the following cycle.
  // ------------------------------------------------------------------
  logic [NodeW-1:0] sel_idx;
  logic             sel_hz;
  logic [LinkW-1:0] sel_one, zero_link, link_in, link_item, link_in_m1, link_item_m1;

  always_comb begin
    sel_idx      = at_root_q ? '0 : cur_idx_q;
    sel_hz       = at_root_q ? root_hz_q : cur_hz_q;
    sel_one      = at_root_q ? root_one_q : cur_one_q;
    // The zero child sits at the next index; its link is that index plus one.
    zero_link    = sel_hz ? (LinkW'(sel_idx) + LinkW'(2)) : '0;
    link_in      = in_i.code_bit ? sel_one : zero_link;
    link_item    = item_q.code_bit ? sel_one : zero_link;
    link_in_m1   = link_in - LinkW'(1);
    link_item_m1 = link_item - LinkW'(1);
  end

  // Stack top read address: the topmost one-side slot.
  logic [StackCntW-1:0] s1_cnt_m1;
  assign s1_cnt_m1 = s1_cnt_q - StackCntW'(1);

  // ------------------------------------------------------------------
  // Memories: reads at acceptance, writes when the item completes. The two
  // never fall in the same cycle, and an item is only taken after the
  // previous one has written back, so no forwarding is needed.
  // ------------------------------------------------------------------
  logic             lbl_we, hz_we, one_we, stk_we;
  logic [NodeW-1:0] lbl_waddr, hz_waddr, one_waddr;
  logic [StackW-1:0] stk_waddr;
  logic [7:0]       lbl_wdata;
  logic             hz_wdata;
  logic [LinkW-1:0] one_wdata;
  logic [NodeW-1:0] stk_wdata;

  always_ff @(posedge clk_i) begin
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    if (hz_we) begin
      hz_mem[hz_waddr] <= hz_wdata;
    end
    if (one_we) begin
      one_mem[one_waddr] <= one_wdata;
    end
    if (in_fire) begin
      rd_lbl_q <= lbl_mem[link_in_m1[NodeW-1:0]];
      rd_hz_q  <= hz_mem[link_in_m1[NodeW-1:0]];
      rd_one_q <= one_mem[link_in_m1[NodeW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (in_fire) begin
      stk_rd_q <= stk_mem[s1_cnt_m1[StackW-1:0]];
    end
  end

  // ------------------------------------------------------------------
  // Item processing, in the cycle after acceptance.
  // ------------------------------------------------------------------
  result_t              res;
  logic [StackCntW-1:0] ptop, ptop_d;
  logic [LinkW-1:0]     nodes_used_m1;
  logic [NodeW-1:0]     fresh_idx, parent;
  logic                 side_one, is_empty, full;

  always_comb begin
    ptop          = s1_cnt_q + StackCntW'(zflag_q);
    nodes_used_m1 = nodes_used_q - LinkW'(1);
    fresh_idx     = nodes_used_q[NodeW-1:0];
    // A zero-side slot on top always belongs to the newest node.
    parent        = zflag_q ? nodes_used_m1[NodeW-1:0] : stk_rd_q;
    side_one      = !zflag_q;
    is_empty      = (item_q.tree_char == EmptyMark);
    full          = (nodes_used_q >= LinkW'(NodeCapacity)) ||
                    (ptop >= StackCntW'(StackDepth));
  end

  always_comb begin
    nodes_used_d = nodes_used_q;
    s1_cnt_d     = s1_cnt_q;
    zflag_d      = zflag_q;
    root_seen_d  = root_seen_q;
    load_done_d  = load_done_q;
    at_root_d    = at_root_q;
    root_label_d = root_label_q;
    root_hz_d    = root_hz_q;
    root_one_d   = root_one_q;
    cur_idx_d    = cur_idx_q;
    cur_hz_d     = cur_hz_q;
    cur_one_d    = cur_one_q;

    lbl_we    = 1'b0;
    lbl_waddr = fresh_idx;
    lbl_wdata = item_q.tree_char;
    hz_we     = 1'b0;
    hz_waddr  = parent;
    hz_wdata  = !is_empty;
    one_we    = 1'b0;
    one_waddr = parent;
    one_wdata = is_empty ? '0 : (nodes_used_q + LinkW'(1));
    stk_we    = 1'b0;
    stk_waddr = zflag_q ? s1_cnt_q[StackW-1:0] : s1_cnt_m1[StackW-1:0];
    stk_wdata = fresh_idx;

    res.symbol_valid = 1'b0;
    res.symbol       = '0;
    res.status       = STAT_OK;

    if (busy_q) begin
      unique case (item_q.func)
        FUNC_CLEAR: begin
          nodes_used_d = '0;
          s1_cnt_d     = '0;
          zflag_d      = 1'b0;
          root_seen_d  = 1'b0;
          load_done_d  = 1'b0;
          at_root_d    = 1'b1;
        end

        FUNC_TREE_BYTE: begin
          if (load_done_q) begin
            res.status = STAT_TREE_DONE;
          end else if (!root_seen_q) begin
            root_seen_d = 1'b1;
            if (is_empty) begin
              // Empty tree: complete at once with no nodes.
              load_done_d = 1'b1;
            end else begin
              lbl_we       = 1'b1;
              root_label_d = item_q.tree_char;
              root_hz_d    = 1'b0;
              root_one_d   = '0;
              stk_we       = 1'b1;
              stk_waddr    = s1_cnt_q[StackW-1:0];
              s1_cnt_d     = s1_cnt_q + StackCntW'(1);
              zflag_d      = 1'b1;
              nodes_used_d = nodes_used_q + LinkW'(1);
            end
          end else if (ptop == '0) begin
            load_done_d = 1'b1;
            res.status  = STAT_TREE_DONE;
          end else if (!is_empty && full) begin
            res.status = STAT_OVERFLOW;
          end else begin
            // Fill the slot on top of the stack.
            hz_we  = !side_one;
            one_we = side_one;
            if (parent == '0) begin
              if (side_one) begin
                root_one_d = one_wdata;
              end else begin
                root_hz_d = hz_wdata;
              end
            end
            if (!is_empty) begin
              // Pop the slot, then push the new node's one and zero slots.
              lbl_we       = 1'b1;
              stk_we       = 1'b1;
              s1_cnt_d     = zflag_q ? (s1_cnt_q + StackCntW'(1)) : s1_cnt_q;
              zflag_d      = 1'b1;
              nodes_used_d = nodes_used_q + LinkW'(1);
            end else if (zflag_q) begin
              zflag_d = 1'b0;
            end else begin
              s1_cnt_d = s1_cnt_m1;
            end
            if (ptop_d == '0) begin
              load_done_d = 1'b1;
            end
          end
        end

        FUNC_CODE_BIT: begin
          if (!load_done_q) begin
            res.status = STAT_NOT_READY;
          end else if (nodes_used_q == '0) begin
            res.status = STAT_EMPTY_CHILD;
          end else if (!root_hz_q && (root_one_q == '0)) begin
            // A root without children decodes to its own label every bit.
            res.symbol_valid = 1'b1;
            res.symbol       = root_label_q;
            at_root_d        = 1'b1;
          end else if (link_item == '0) begin
            res.status = STAT_EMPTY_CHILD;
            at_root_d  = 1'b1;
          end else if (!rd_hz_q && (rd_one_q == '0)) begin
            res.symbol_valid = 1'b1;
            res.symbol       = rd_lbl_q;
            at_root_d        = 1'b1;
          end else begin
            cur_idx_d = link_item_m1[NodeW-1:0];
            cur_hz_d  = rd_hz_q;
            cur_one_d = rd_one_q;
            at_root_d = 1'b0;
          end
        end

        default: begin
        end
      endcase
    end

    res.tree_ready = load_done_d;
  end

  assign ptop_d = s1_cnt_d + StackCntW'(zflag_d);

  // ------------------------------------------------------------------
  // Registers.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      nodes_used_q <= '0;
      s1_cnt_q     <= '0;
      zflag_q      <= 1'b0;
      root_seen_q  <= 1'b0;
      load_done_q  <= 1'b0;
      at_root_q    <= 1'b1;
    end else begin
      busy_q       <= in_fire;
      nodes_used_q <= nodes_used_d;
      s1_cnt_q     <= s1_cnt_d;
      zflag_q      <= zflag_d;
      root_seen_q  <= root_seen_d;
      load_done_q  <= load_done_d;
      at_root_q    <= at_root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.func      <= in_i.func;
      item_q.tree_char <= in_i.tree_char;
      item_q.code_bit  <= in_i.code_bit;
    end
    root_label_q <= root_label_d;
    root_hz_q    <= root_hz_d;
    root_one_q   <= root_one_d;
    cur_idx_q    <= cur_idx_d;
    cur_hz_q     <= cur_hz_d;
    cur_one_q    <= cur_one_d;
  end

  // ------------------------------------------------------------------
  // Two-entry output queue; every processed item pushes one result.
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (busy_q) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (out_fire) begin
        oq_rd_q <= !oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_q + 2'(busy_q) - 2'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  assign out_o.valid        = (oq_cnt_q != 2'd0);
  assign out_o.symbol_valid = oq_q[oq_rd_q].symbol_valid;
  assign out_o.symbol       = oq_q[oq_rd_q].symbol;
  assign out_o.tree_ready   = oq_q[oq_rd_q].tree_ready;
  assign out_o.status       = oq_q[oq_rd_q].status;

endmodule

@@ sim/htd_decode_tracker_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class for the Huffman tree decoder test: a decoder of its own
// that predicts each result item, and the check of the items the core returns.
// Depends on htd_pkg for sizes, codes and the item and result types.
package htd_decode_tracker_pkg;
  import htd_pkg::*;

  class htd_decode_tracker;
    // Node table and stack of child slots still to be filled.
    logic [7:0]           label_mem [NodeCapacity];
    logic [LinkW-1:0]     zero_link [NodeCapacity];
    logic [LinkW-1:0]     one_link  [NodeCapacity];
    logic [LinkW-1:0]     node_count;
    logic [NodeW-1:0]     slot_node [StackDepth];
    logic                 slot_side [StackDepth];
    logic [StackCntW-1:0] slot_count;
    logic                 tree_started;
    logic                 tree_complete;
    logic [NodeW-1:0]     walk_node;

    result_t     due_results[$];
    int unsigned errors;
    int unsigned reported;

    function new();
      errors   = 0;
      reported = 0;
      clear_tree();
    endfunction

    function void clear_tree();
      node_count    = '0;
      slot_count    = '0;
      tree_started  = 1'b0;
      tree_complete = 1'b0;
      walk_node     = '0;
    endfunction

    // Creates a node and pushes its one slot, then its zero slot on top.
    function logic [LinkW-1:0] add_node(logic [7:0] lbl);
      logic [NodeW-1:0] idx;
      idx = node_count[NodeW-1:0];
      label_mem[idx] = lbl;
      zero_link[idx] = '0;
      one_link[idx]  = '0;
      node_count     = node_count + 1'b1;
      slot_node[slot_count]        = idx;
      slot_side[slot_count]        = 1'b1;
      slot_node[slot_count + 1'b1] = idx;
      slot_side[slot_count + 1'b1] = 1'b0;
      slot_count = slot_count + 2'd2;
      return LinkW'(idx) + 1'b1;
    endfunction

    function status_e load_tree_byte(logic [7:0] lbl);
      logic [StackCntW-1:0] top;
      logic [NodeW-1:0]     parent;
      logic                 side;
      logic [LinkW-1:0]     link;
      if (tree_complete) return STAT_TREE_DONE;
      if (!tree_started) begin
        tree_started = 1'b1;
        if (lbl == EmptyMark) tree_complete = 1'b1;
        else void'(add_node(lbl));
        return STAT_OK;
      end
      if (slot_count == 0 || slot_count > StackDepth) begin
        tree_complete = 1'b1;
        return STAT_TREE_DONE;
      end
      top    = slot_count - 1'b1;
      parent = slot_node[top];
      side   = slot_side[top];
      link   = '0;
      if (lbl != EmptyMark) begin
        if (node_count >= NodeCapacity || slot_count + 1 > StackDepth) return STAT_OVERFLOW;
        slot_count = top;
        link = add_node(lbl);
      end else begin
        slot_count = top;
      end
      if (side) one_link[parent] = link;
      else zero_link[parent] = link;
      if (slot_count == 0) tree_complete = 1'b1;
      return STAT_OK;
    endfunction

    function status_e walk_code_bit(logic code_b, output logic found, output logic [7:0] lbl);
      logic [LinkW-1:0] link;
      logic [NodeW-1:0] child;
      found = 1'b0;
      lbl   = '0;
      if (!tree_complete) return STAT_NOT_READY;
      if (node_count == 0) return STAT_EMPTY_CHILD;
      if (zero_link[0] == 0 && one_link[0] == 0) begin
        found     = 1'b1;
        lbl       = label_mem[0];
        walk_node = '0;
        return STAT_OK;
      end
      if (walk_node >= node_count) walk_node = '0;
      link = code_b ? one_link[walk_node] : zero_link[walk_node];
      if (link == 0 || link > node_count) begin
        walk_node = '0;
        return STAT_EMPTY_CHILD;
      end
      child = NodeW'(link - 1'b1);
      if (zero_link[child] == 0 && one_link[child] == 0) begin
        found     = 1'b1;
        lbl       = label_mem[child];
        walk_node = '0;
      end else begin
        walk_node = child;
      end
      return STAT_OK;
    endfunction

    // Called for every input item the core has taken.
    function void note_item(item_t it);
      result_t    r;
      logic       found;
      logic [7:0] lbl;
      r = '0;
      case (it.func)
        FUNC_CLEAR:     clear_tree();
        FUNC_TREE_BYTE: r.status = load_tree_byte(it.tree_char);
        FUNC_CODE_BIT: begin
          r.status       = walk_code_bit(it.code_bit, found, lbl);
          r.symbol_valid = found;
          r.symbol       = lbl;
        end
        default: ;
      endcase
      r.tree_ready = tree_complete;
      due_results.insert(due_results.size(), r);
    endfunction

    // Called for every result item the test has taken from the core.
    function void check_result(logic sv, logic [7:0] sym, logic tr, logic [2:0] st);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result with nothing due: valid=%0b symbol=%02h ready=%0b status=%0d",
                   $realtime, sv, sym, tr, st);
        end
        return;
      end
      want = due_results.pop_front();
      if (want.symbol_valid !== sv || want.symbol !== sym || want.tree_ready !== tr ||
          want.status !== st) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: mismatch: expected valid=%0b symbol=%02h ready=%0b status=%0d",
                   $realtime, want.symbol_valid, want.symbol, want.tree_ready, want.status);
          $display("%0t:           got      valid=%0b symbol=%02h ready=%0b status=%0d",
                   $realtime, sv, sym, tr, st);
        end
      end
    endfunction

    function void close_out();
      if (due_results.size() != 0) begin
        errors += due_results.size();
        $display("%0d result items never arrived", due_results.size());
      end
    endfunction
  endclass

endpackage

@@ sim/huffman_tree_decoder_core_test.sv @@
`timescale 1ns / 1ps
// Test of the Huffman tree decoder core: tree loads and code bits with random
// gaps and stalls, each result checked against the decode tracker's prediction.
// Depends on htd_pkg, the channels in htd_if.sv and htd_decode_tracker_pkg.
module huffman_tree_decoder_core_test;
  import htd_pkg::*;
  import htd_decode_tracker_pkg::*;

  // The one func value the core leaves unused; it must be ignored.
  localparam logic [1:0] FuncUnused = 2'd3;
  // Far above the slowest correct run.
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 400;

  logic clk = 1'b0;
  logic rst_n;

  htd_in_if  in_ch ();
  htd_out_if out_ch ();

  huffman_tree_decoder_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #2 clk = ~clk;

  htd_decode_tracker tracker;

  // Random gaps on both sides; cleared for a stretch in the middle of the run.
  bit          gaps_on = 1'b1;
  // Cycles the receiver still has to hold off; set by the stimulus at a
  // falling edge and counted down by the receiver at rising edges.
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  // Preorder bytes of the tree under construction.
  logic [7:0] tree_bytes[$];

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // A node label: any byte but the empty-child mark.
  function automatic logic [7:0] pick_label();
    logic [7:0] l;
    l = any_byte();
    while (l == EmptyMark) l = any_byte();
    return l;
  endfunction

  // Builds a random preorder tree. open counts child slots still to be
  // filled: an inner node fills one and opens two, a leaf (label plus two
  // empty marks) or a lone empty mark fills one. Inner nodes are limited by
  // the budget, so the walk always closes. A few trees are empty outright.
  function automatic void build_tree(int unsigned inner_budget, int unsigned hole_pct);
    int unsigned open;
    int unsigned inner;
    tree_bytes.delete();
    if (chance(3)) begin
      tree_bytes.insert(tree_bytes.size(), EmptyMark);
      return;
    end
    open  = 1;
    inner = inner_budget;
    while (open > 0) begin
      if (inner > 0 && chance(50)) begin
        tree_bytes.insert(tree_bytes.size(), pick_label());
        open++;
        inner--;
      end else if (chance(hole_pct)) begin
        tree_bytes.insert(tree_bytes.size(), EmptyMark);
        open--;
      end else begin
        tree_bytes.insert(tree_bytes.size(), pick_label());
        tree_bytes.insert(tree_bytes.size(), EmptyMark);
        tree_bytes.insert(tree_bytes.size(), EmptyMark);
        open--;
      end
    end
  endfunction

  // Offers one item and returns at the rising edge that took it. Ready is
  // looked at on the falling edge, where it is settled for the next rising
  // edge. valid stays high on return, so the caller either offers the next
  // item in the same step or lowers valid before letting time pass.
  task automatic send_item(logic [1:0] f, logic [7:0] c, logic b);
    item_t it;
    logic  took;
    it.func      = f;
    it.tree_char = c;
    it.code_bit  = b;
    while (gaps_on && chance(32)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.tree_char <= c;
    in_ch.code_bit  <= b;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end
    tracker.note_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(FUNC_TREE_BYTE, c, any_bit());
  endtask

  task automatic send_code(logic b);
    send_item(FUNC_CODE_BIT, any_byte(), b);
  endtask

  task automatic send_clear();
    send_item(FUNC_CLEAR, any_byte(), any_bit());
  endtask

  // The sender pauses until every result item has come back.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // Starts a long receiver hold-off; the sender keeps offering afterwards,
  // so the output queue fills and the core stops taking input.
  task automatic hold_receiver(int unsigned cycles);
    in_ch.valid <= 1'b0;
    @(negedge clk);
    hold_left = cycles;
    @(posedge clk);
  endtask

  // One decode session: clear, load a tree, then decode a run of bits.
  // Some sessions are broken: bits before the tree is complete, a tree cut
  // short, unused func values in the stream, or extra bytes after the load.
  task automatic run_episode(int unsigned inner_budget, int unsigned hole_pct);
    int unsigned cut;
    int unsigned idx;
    int unsigned nbits;
    send_clear();
    if (chance(15)) send_code(any_bit());
    build_tree(inner_budget, hole_pct);
    cut = tree_bytes.size();
    if (chance(8)) cut = $urandom_range(0, tree_bytes.size() - 1);
    for (idx = 0; idx < cut; idx++) begin
      if (chance(4)) send_item(FuncUnused, any_byte(), any_bit());
      send_byte(tree_bytes[idx]);
    end
    if (chance(20)) send_byte(any_byte());
    nbits = $urandom_range(4, 40);
    repeat (nbits) begin
      if (chance(3)) send_item(FuncUnused, any_byte(), any_bit());
      send_code(any_bit());
    end
  endtask

  // A chain of labels, each the zero child of the one before, grows the slot
  // stack by one per label until it is full, and one more label is refused
  // with an overflow. Pairs of an empty mark and a label then add one node
  // each at a constant stack depth until the node table is full, and a
  // further label is refused as well. The load never completes, so code bits
  // are refused as not ready.
  task automatic overflow_limits();
    send_clear();
    send_byte(pick_label());
    repeat (StackDepth - 2) send_byte(pick_label());
    send_byte(pick_label());
    send_code(any_bit());
    repeat (NodeCapacity - StackDepth + 1) begin
      send_byte(EmptyMark);
      send_byte(pick_label());
    end
    send_byte(EmptyMark);
    send_byte(pick_label());
    send_code(any_bit());
    repeat (4) send_byte(EmptyMark);
  endtask

  // Receiver: decides ready at each rising edge and takes a result at the
  // next one when valid and ready are both high on the falling edge between.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !gaps_on || !chance(32);
      end
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.symbol_valid, out_ch.symbol, out_ch.tree_ready,
                             out_ch.status);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned episode;
    int unsigned random_start;
    tracker = new();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_CLEAR;
    in_ch.tree_char <= '0;
    in_ch.code_bit  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A code bit before any tree is refused as not ready.
    send_clear();
    send_code(1'b1);
    // An empty tree completes at once; every bit then hits an empty child,
    // and a further byte is refused since the tree is already complete.
    send_byte(EmptyMark);
    send_code(1'b0);
    send_byte(8'hFF);
    send_item(FuncUnused, 8'h00, 1'b0);
    // A root with no children emits its label for every bit.
    send_clear();
    send_byte(8'h00);
    send_byte(EmptyMark);
    send_byte(EmptyMark);
    send_code(1'b0);
    send_code(1'b1);
    // Root with a leaf on its zero side and an empty one side: the empty
    // child on the path sends the walk back to the root.
    send_clear();
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(EmptyMark);
    send_byte(EmptyMark);
    send_byte(EmptyMark);
    send_code(1'b0);
    send_code(1'b1);
    send_code(1'b0);
    wait_results_done();

    // Random sessions: mostly well-formed trees with random labels, some
    // root-only, some with holes, broken ones mixed in by run_episode.
    random_start = items_sent;
    episode = 0;
    while (items_sent - random_start < RandomItems) begin
      gaps_on = !(episode >= 3 && episode < 6);
      if (episode == 1) hold_receiver(80);
      if (episode == 2) wait_results_done();
      run_episode(chance(10) ? 0 : $urandom_range(1, 14), chance(25) ? 30 : 3);
      episode++;
    end
    gaps_on = 1'b1;
    overflow_limits();

    wait_results_done();
    repeat (8) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d errors", tracker.errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ huffman_tree_decoder_core.f @@
hdl/htd_pkg.sv
hdl/htd_if.sv
hdl/huffman_tree_decoder_core.sv
sim/htd_decode_tracker_pkg.sv
sim/huffman_tree_decoder_core_test.sv
